@@ rtl/sseg_pkg.sv @@
// shared types, codes, font table and helpers for the seven-segment command encoder
package sseg_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int PC_W        = 4;
    localparam int CNT_W       = 2;
    localparam int REST_W      = 14;

    // request codes
    localparam logic [2:0] REQ_SET_SEGMENTS   = 3'd0;
    localparam logic [2:0] REQ_SHOW_DIGIT     = 3'd1;
    localparam logic [2:0] REQ_SHOW_NUMBER    = 3'd2;
    localparam logic [2:0] REQ_SET_BRIGHTNESS = 3'd3;
    localparam logic [2:0] REQ_CLEAR          = 3'd4;
    localparam logic [2:0] REQ_INIT           = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_NOT_READY = 2'd2;

    // bus constants
    localparam logic [7:0]  ADDR_SYSTEM     = 8'h48;
    localparam logic [7:0]  ADDR_DIGIT_BASE = 8'h68;
    localparam logic [3:0]  MODE_EIGHT_SEG  = 4'h1;
    localparam logic [3:0]  BRIGHT_MAX      = 4'd8;
    localparam logic [15:0] NUMBER_MAX      = 16'd9999;
    localparam logic [15:0] DIGIT_MAX       = 16'd15;
    localparam logic [15:0] LEVEL_MAX       = 16'd8;

    // divide by ten: q = (x * RECIP_10) >> RECIP_SHIFT, exact for every 16-bit x
    localparam logic [15:0] RECIP_10    = 16'd52429;
    localparam int          RECIP_SHIFT = 19;

    // micro-op actions
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_EMIT = 2'd1;
    localparam logic [1:0] ACT_DIV  = 2'd2;

    // emit sources
    localparam logic [2:0] SRC_ERR        = 3'd0;
    localparam logic [2:0] SRC_RAW        = 3'd1;
    localparam logic [2:0] SRC_FONT       = 3'd2;
    localparam logic [2:0] SRC_NUM        = 3'd3;
    localparam logic [2:0] SRC_BLANK      = 3'd4;
    localparam logic [2:0] SRC_BRIGHT_VAL = 3'd5;
    localparam logic [2:0] SRC_BRIGHT_DEF = 3'd6;

    // jump conditions
    localparam logic [1:0] COND_SEQ    = 2'd0;
    localparam logic [1:0] COND_LOOP   = 2'd1;
    localparam logic [1:0] COND_BADDEF = 2'd2;

    // program entry points
    localparam logic [PC_W-1:0] PC_ERR        = 4'd0;
    localparam logic [PC_W-1:0] PC_RAW        = 4'd1;
    localparam logic [PC_W-1:0] PC_FONT       = 4'd2;
    localparam logic [PC_W-1:0] PC_BRIGHT     = 4'd3;
    localparam logic [PC_W-1:0] PC_CLEAR      = 4'd4;
    localparam logic [PC_W-1:0] PC_INIT       = 4'd5;
    localparam logic [PC_W-1:0] PC_INIT_CHK   = 4'd6;
    localparam logic [PC_W-1:0] PC_INIT_BRT   = 4'd7;
    localparam logic [PC_W-1:0] PC_NUM_DIV    = 4'd8;
    localparam logic [PC_W-1:0] PC_NUM_EMIT   = 4'd9;
    localparam logic [PC_W-1:0] PC_LAST       = 4'd9;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIGIT_COUNT - 1);

    typedef struct packed {
        logic [1:0]      act;
        logic [2:0]      src;
        logic [1:0]      cond;
        logic [PC_W-1:0] target;
        logic            inc;
        logic            fin;
    } ctrl_t;

    typedef struct packed {
        logic       write_valid;
        logic [7:0] address;
        logic [7:0] data;
        logic [1:0] status;
    } emit_t;

    // seven-segment font for hex digits
    function automatic logic [7:0] seg_font(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'h0: s = 8'h3F;
            4'h1: s = 8'h06;
            4'h2: s = 8'h5B;
            4'h3: s = 8'h4F;
            4'h4: s = 8'h66;
            4'h5: s = 8'h6D;
            4'h6: s = 8'h7D;
            4'h7: s = 8'h07;
            4'h8: s = 8'h7F;
            4'h9: s = 8'h6F;
            4'hA: s = 8'h77;
            4'hB: s = 8'h7C;
            4'hC: s = 8'h39;
            4'hD: s = 8'h5E;
            4'hE: s = 8'h79;
            4'hF: s = 8'h71;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // brightness level to system command data byte
    function automatic logic [7:0] bright_code(input logic [3:0] level);
        logic [3:0] lm1;
        lm1 = level - 4'd1;
        return (level == 4'd0) ? 8'h00 : {lm1, MODE_EIGHT_SEG};
    endfunction

    // digit register address for a position
    function automatic logic [7:0] digit_addr(input logic [CNT_W-1:0] p);
        return ADDR_DIGIT_BASE + {5'b0, p, 1'b0};
    endfunction

endpackage

@@ rtl/seven_segment_command_encoder.sv @@
// top level: request dispatch, microcode sequencer and result register
// one request in flight; a request is taken in the cycle after the previous one finishes
// on accept the entry point and operands are registered; clear makes four writes and
// single-write requests one; init makes four blank writes, a default check, then a
// brightness write or error result; show number four divide-by-ten steps, four writes
// result stalls hold emit steps; reset clears the ready flag and sets brightness to 4
module seven_segment_command_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  req_type,
    input  logic [2:0]  position,
    input  logic [15:0] value,
    input  logic [7:0]  segments,
    input  logic        dot,
    input  logic        zero_fill,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        write_valid,
    output logic [7:0]  address,
    output logic [7:0]  data,
    output logic [1:0]  status,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);

    logic                       busy_reg;
    logic                       busy_next;
    logic [sseg_pkg::PC_W-1:0]  pc_reg;
    logic [sseg_pkg::PC_W-1:0]  pc_next;
    logic [sseg_pkg::CNT_W-1:0] cnt_reg;
    logic [sseg_pkg::CNT_W-1:0] cnt_next;
    logic                       ready_flag_reg;
    logic [3:0]                 def_level_reg;
    logic                       out_valid_reg;
    sseg_pkg::emit_t            out_reg;
    logic                       out_last_reg;

    sseg_pkg::ctrl_t            ctrl;
    sseg_pkg::emit_t            emit;
    logic                       accept;
    logic                       emitting;
    logic                       can_load;
    logic                       advance;
    logic                       jump;
    logic                       done;
    logic [sseg_pkg::PC_W-1:0]  entry_pc;
    logic [1:0]                 entry_status;

    assign in_ready  = !busy_reg;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // request checks and program entry
    always_comb
    begin
        entry_pc     = sseg_pkg::PC_ERR;
        entry_status = sseg_pkg::ST_INVALID;
        if (req_type > sseg_pkg::REQ_INIT)
        begin
            entry_pc     = sseg_pkg::PC_ERR;
            entry_status = sseg_pkg::ST_INVALID;
        end
        else if (req_type == sseg_pkg::REQ_INIT)
        begin
            entry_pc = sseg_pkg::PC_INIT;
        end
        else if (!ready_flag_reg)
        begin
            entry_status = sseg_pkg::ST_NOT_READY;
        end
        else
        begin
            case (req_type)
                sseg_pkg::REQ_SET_SEGMENTS:
                begin
                    if (!position[2])
                    begin
                        entry_pc = sseg_pkg::PC_RAW;
                    end
                end
                sseg_pkg::REQ_SHOW_DIGIT:
                begin
                    if (!position[2] && value <= sseg_pkg::DIGIT_MAX)
                    begin
                        entry_pc = sseg_pkg::PC_FONT;
                    end
                end
                sseg_pkg::REQ_SHOW_NUMBER:
                begin
                    if (value <= sseg_pkg::NUMBER_MAX)
                    begin
                        entry_pc = sseg_pkg::PC_NUM_DIV;
                    end
                end
                sseg_pkg::REQ_SET_BRIGHTNESS:
                begin
                    if (value <= sseg_pkg::LEVEL_MAX)
                    begin
                        entry_pc = sseg_pkg::PC_BRIGHT;
                    end
                end
                sseg_pkg::REQ_CLEAR:
                begin
                    entry_pc = sseg_pkg::PC_CLEAR;
                end
                default:
                begin
                    entry_pc = sseg_pkg::PC_ERR;
                end
            endcase
        end
    end

    sseg_ucode_rom u_rom (
        .pc   (pc_reg),
        .ctrl (ctrl)
    );

    sseg_dp u_dp (
        .clk          (clk),
        .load         (accept),
        .step         (advance),
        .load_status  (entry_status),
        .position     (position),
        .value        (value),
        .segments     (segments),
        .dot          (dot),
        .zero_fill    (zero_fill),
        .ctrl         (ctrl),
        .cnt          (cnt_reg),
        .def_level    (def_level_reg),
        .emit         (emit)
    );

    // step control and conditional jumps
    always_comb
    begin
        emitting = (ctrl.act == sseg_pkg::ACT_EMIT);
        can_load = !out_valid_reg || out_ready;
        advance  = busy_reg && (!emitting || can_load);
        case (ctrl.cond)
            sseg_pkg::COND_LOOP:   jump = (cnt_reg != sseg_pkg::CNT_LAST);
            sseg_pkg::COND_BADDEF: jump = (def_level_reg > sseg_pkg::BRIGHT_MAX);
            default:               jump = 1'b0;
        endcase
        done      = ctrl.fin && !jump;
        busy_next = busy_reg;
        pc_next   = pc_reg;
        cnt_next  = cnt_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            pc_next   = entry_pc;
            cnt_next  = '0;
        end
        else if (advance)
        begin
            pc_next  = jump ? ctrl.target : pc_reg + 4'd1;
            cnt_next = ctrl.inc ? cnt_reg + 2'd1 : cnt_reg;
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // sequencer and flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            pc_reg         <= sseg_pkg::PC_ERR;
            cnt_reg        <= '0;
            ready_flag_reg <= 1'b0;
            def_level_reg  <= 4'd4;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
            cnt_reg  <= cnt_next;
            if (accept && req_type == sseg_pkg::REQ_INIT)
            begin
                ready_flag_reg <= 1'b1;
            end
            if (cfg_valid)
            begin
                def_level_reg <= cfg_data;
            end
            if (advance && emitting)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance && emitting)
        begin
            out_reg      <= emit;
            out_last_reg <= done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign write_valid = out_reg.write_valid;
    assign address     = out_reg.address;
    assign data        = out_reg.data;
    assign status      = out_reg.status;
    assign last        = out_last_reg;

    // an accepted item starts the sequencer
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("sequencer not busy after accept");

    // program counter stays inside the program while running
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pc_reg <= sseg_pkg::PC_LAST)
        else $error("program counter out of range");

    // error results carry no write and end the request
    a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != sseg_pkg::ST_OK)
            |-> (!out_reg.write_valid && out_last_reg))
        else $error("error result with a write or not last");

    // ready flag is never cleared once set
    a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(ready_flag_reg))
        else $error("ready flag cleared");

endmodule

@@ rtl/sseg_ucode_rom.sv @@
// microcode program store: one control word per step
module sseg_ucode_rom (
    input  logic [sseg_pkg::PC_W-1:0] pc,
    output sseg_pkg::ctrl_t           ctrl
);

    // program table
    always_comb
    begin
        ctrl = '{act: sseg_pkg::ACT_NONE, src: sseg_pkg::SRC_ERR, cond: sseg_pkg::COND_SEQ,
                 target: sseg_pkg::PC_ERR, inc: 1'b0, fin: 1'b1};
        case (pc)
            sseg_pkg::PC_ERR:
            begin
                ctrl.act = sseg_pkg::ACT_EMIT;
                ctrl.src = sseg_pkg::SRC_ERR;
            end
            sseg_pkg::PC_RAW:
            begin
                ctrl.act = sseg_pkg::ACT_EMIT;
                ctrl.src = sseg_pkg::SRC_RAW;
            end
            sseg_pkg::PC_FONT:
            begin
                ctrl.act = sseg_pkg::ACT_EMIT;
                ctrl.src = sseg_pkg::SRC_FONT;
            end
            sseg_pkg::PC_BRIGHT:
            begin
                ctrl.act = sseg_pkg::ACT_EMIT;
                ctrl.src = sseg_pkg::SRC_BRIGHT_VAL;
            end
            sseg_pkg::PC_CLEAR:
            begin
                ctrl.act    = sseg_pkg::ACT_EMIT;
                ctrl.src    = sseg_pkg::SRC_BLANK;
                ctrl.cond   = sseg_pkg::COND_LOOP;
                ctrl.target = sseg_pkg::PC_CLEAR;
                ctrl.inc    = 1'b1;
            end
            sseg_pkg::PC_INIT:
            begin
                ctrl.act    = sseg_pkg::ACT_EMIT;
                ctrl.src    = sseg_pkg::SRC_BLANK;
                ctrl.cond   = sseg_pkg::COND_LOOP;
                ctrl.target = sseg_pkg::PC_INIT;
                ctrl.inc    = 1'b1;
                ctrl.fin    = 1'b0;
            end
            sseg_pkg::PC_INIT_CHK:
            begin
                ctrl.cond   = sseg_pkg::COND_BADDEF;
                ctrl.target = sseg_pkg::PC_ERR;
                ctrl.fin    = 1'b0;
            end
            sseg_pkg::PC_INIT_BRT:
            begin
                ctrl.act = sseg_pkg::ACT_EMIT;
                ctrl.src = sseg_pkg::SRC_BRIGHT_DEF;
            end
            sseg_pkg::PC_NUM_DIV:
            begin
                ctrl.act    = sseg_pkg::ACT_DIV;
                ctrl.cond   = sseg_pkg::COND_LOOP;
                ctrl.target = sseg_pkg::PC_NUM_DIV;
                ctrl.inc    = 1'b1;
                ctrl.fin    = 1'b0;
            end
            sseg_pkg::PC_NUM_EMIT:
            begin
                ctrl.act    = sseg_pkg::ACT_EMIT;
                ctrl.src    = sseg_pkg::SRC_NUM;
                ctrl.cond   = sseg_pkg::COND_LOOP;
                ctrl.target = sseg_pkg::PC_NUM_EMIT;
                ctrl.inc    = 1'b1;
            end
            default:
            begin
                ctrl.act = sseg_pkg::ACT_NONE;
            end
        endcase
    end

endmodule

@@ rtl/sseg_dp.sv @@
// datapath: request operands, divide-by-ten digit split and write formatting
module sseg_dp (
    input  logic                          clk,
    input  logic                          load,
    input  logic                          step,
    input  logic [1:0]                    load_status,
    input  logic [2:0]                    position,
    input  logic [15:0]                   value,
    input  logic [7:0]                    segments,
    input  logic                          dot,
    input  logic                          zero_fill,
    input  sseg_pkg::ctrl_t               ctrl,
    input  logic [sseg_pkg::CNT_W-1:0]    cnt,
    input  logic [3:0]                    def_level,
    output sseg_pkg::emit_t               emit
);

    logic [sseg_pkg::CNT_W-1:0]   pos_reg;
    logic [7:0]                   seg_reg;
    logic [3:0]                   val_reg;
    logic                         dot_reg;
    logic [1:0]                   stat_reg;
    logic [sseg_pkg::REST_W-1:0]  rest_reg;
    logic [sseg_pkg::REST_W-1:0]  rest_next;
    logic [3:0]                   digs_reg [sseg_pkg::DIGIT_COUNT];
    logic                         started_reg;
    logic                         started_next;
    logic [sseg_pkg::REST_W+15:0] prod;
    logic [sseg_pkg::REST_W-1:0]  quot;
    logic [sseg_pkg::REST_W-1:0]  quot_x10;
    logic [3:0]                   rem;
    logic [3:0]                   cur_dig;
    logic                         show;

    // divide by ten through the reciprocal
    assign prod      = {16'b0, rest_reg} * {{sseg_pkg::REST_W{1'b0}}, sseg_pkg::RECIP_10};
    assign quot      = sseg_pkg::REST_W'(prod >> sseg_pkg::RECIP_SHIFT);
    assign quot_x10  = (quot << 3) + (quot << 1);
    assign rem       = 4'(rest_reg - quot_x10);
    assign rest_next = quot;

    // digit blanking for show number
    assign cur_dig      = digs_reg[cnt];
    assign show         = started_reg || (cur_dig != 4'd0) || (cnt == sseg_pkg::CNT_LAST);
    assign started_next = started_reg || (cur_dig != 4'd0);

    // operand registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pos_reg     <= position[sseg_pkg::CNT_W-1:0];
            seg_reg     <= segments;
            val_reg     <= value[3:0];
            dot_reg     <= dot;
            stat_reg    <= load_status;
            rest_reg    <= value[sseg_pkg::REST_W-1:0];
            started_reg <= zero_fill;
        end
        else if (step)
        begin
            if (ctrl.act == sseg_pkg::ACT_DIV)
            begin
                rest_reg <= rest_next;
                for (int i = sseg_pkg::DIGIT_COUNT - 1; i > 0; i--)
                begin
                    digs_reg[i] <= digs_reg[i-1];
                end
                digs_reg[0] <= rem;
            end
            if (ctrl.act == sseg_pkg::ACT_EMIT && ctrl.src == sseg_pkg::SRC_NUM)
            begin
                started_reg <= started_next;
            end
        end
    end

    // write formatting
    always_comb
    begin
        emit = '{write_valid: 1'b1, address: sseg_pkg::ADDR_SYSTEM, data: 8'h00,
                 status: sseg_pkg::ST_OK};
        case (ctrl.src)
            sseg_pkg::SRC_ERR:
            begin
                emit.write_valid = 1'b0;
                emit.address     = 8'h00;
                emit.status      = stat_reg;
            end
            sseg_pkg::SRC_RAW:
            begin
                emit.address = sseg_pkg::digit_addr(pos_reg);
                emit.data    = seg_reg;
            end
            sseg_pkg::SRC_FONT:
            begin
                emit.address = sseg_pkg::digit_addr(pos_reg);
                emit.data    = sseg_pkg::seg_font(val_reg) | {dot_reg, 7'b0};
            end
            sseg_pkg::SRC_NUM:
            begin
                emit.address = sseg_pkg::digit_addr(cnt);
                emit.data    = show ? sseg_pkg::seg_font(cur_dig) : 8'h00;
            end
            sseg_pkg::SRC_BLANK:
            begin
                emit.address = sseg_pkg::digit_addr(cnt);
            end
            sseg_pkg::SRC_BRIGHT_VAL:
            begin
                emit.data = sseg_pkg::bright_code(val_reg);
            end
            sseg_pkg::SRC_BRIGHT_DEF:
            begin
                emit.data = sseg_pkg::bright_code(def_level);
            end
            default:
            begin
                emit.write_valid = 1'b0;
                emit.address     = 8'h00;
                emit.status      = stat_reg;
            end
        endcase
    end

endmodule
